// ===== sv/src_pkg.sv =====
// Shared constants for the segment run coalescer.
// No dependencies; imported by every module of the block.
package src_pkg;

   localparam int ADDR_BITS_DEFAULT      = 52;
   localparam int MAX_CHUNK_LOG2_DEFAULT = 31;

   localparam int LEN_BITS   = 32;
   localparam int TOTAL_BITS = 16;
   localparam int SHIFT_BITS = 5;

   localparam logic [SHIFT_BITS-1:0] MIN_SEG_SHIFT   = 5'd12;
   localparam logic [SHIFT_BITS-1:0] SEG_SHIFT_RESET = 5'd21;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   // Response queue: room for the two results one segment can raise, plus slack.
   localparam int RSP_DEPTH = 4;

endpackage

// ===== sv/src_step.sv =====
// Per-segment run update: contiguity check, cap split, list flush.
// Depends on src_pkg. Pure combinational; state lives in the top level.
module src_step
   import src_pkg::*;
#(
   parameter int ADDR_BITS      = ADDR_BITS_DEFAULT,
   parameter int MAX_CHUNK_LOG2 = MAX_CHUNK_LOG2_DEFAULT,
   localparam int RES_W         = ADDR_BITS + LEN_BITS + TOTAL_BITS + 1
) (
   input  logic [ADDR_BITS-1:0]  seg_addr,
   input  logic                  list_end,
   input  logic [LEN_BITS-1:0]   seg_size,
   input  logic [ADDR_BITS-1:0]  run_start,
   input  logic [LEN_BITS-1:0]   run_len,
   input  logic [ADDR_BITS-1:0]  run_end,
   input  logic                  run_open,
   input  logic [TOTAL_BITS-1:0] list_chunks,
   output logic [ADDR_BITS-1:0]  run_start_nxt,
   output logic [LEN_BITS-1:0]   run_len_nxt,
   output logic [ADDR_BITS-1:0]  run_end_nxt,
   output logic                  run_open_nxt,
   output logic [TOTAL_BITS-1:0] list_chunks_nxt,
   output logic [1:0]            res_cnt,
   output logic [RES_W-1:0]      res0_data,
   output logic [RES_W-1:0]      res1_data
);

   localparam logic [LEN_BITS-1:0] CHUNK_CAP = LEN_BITS'(64'd1 << MAX_CHUNK_LOG2);

   function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
      sat_inc = (v == TOTAL_MAX) ? v : v + TOTAL_BITS'(1);
   endfunction

   logic                  contig;
   logic                  brk_v, cap_v, fin_v;
   logic [ADDR_BITS-1:0]  start_a, start_b, end_a;
   logic [LEN_BITS-1:0]   len_a, len_b;
   logic [TOTAL_BITS-1:0] tot1, tot2;
   logic [ADDR_BITS+LEN_BITS-1:0] e0, e1, e2, r0, r1;

   always_comb begin
      contig  = run_open && (seg_addr == run_end);
      brk_v   = !contig && run_open && (run_len != '0);
      start_a = contig ? run_start : seg_addr;
      len_a   = contig ? run_len + seg_size : seg_size;
      end_a   = seg_addr + ADDR_BITS'(seg_size);
      // a run that reaches the cap leaves as one chunk; the run goes on empty
      cap_v   = (len_a >= CHUNK_CAP);
      start_b = cap_v ? end_a : start_a;
      len_b   = cap_v ? '0 : len_a;
      fin_v   = list_end && (len_b != '0);

      e0 = {run_start, run_len};
      e1 = {start_a, CHUNK_CAP};
      e2 = {start_b, len_b};

      res_cnt = 2'(brk_v) + 2'(cap_v) + 2'(fin_v);
      r0 = brk_v ? e0 : (cap_v ? e1 : e2);
      r1 = (brk_v && cap_v) ? e1 : e2;

      tot1 = sat_inc(list_chunks);
      tot2 = sat_inc(tot1);
      res0_data = {r0, tot1, (res_cnt == 2'd1)};
      res1_data = {r1, tot2, 1'b1};

      if (list_end) begin
         run_start_nxt   = '0;
         run_len_nxt     = '0;
         run_end_nxt     = '0;
         run_open_nxt    = 1'b0;
         list_chunks_nxt = '0;
      end else begin
         run_start_nxt   = start_b;
         run_len_nxt     = len_b;
         run_end_nxt     = end_a;
         run_open_nxt    = 1'b1;
         case (res_cnt)
            2'd0:    list_chunks_nxt = list_chunks;
            2'd1:    list_chunks_nxt = tot1;
            default: list_chunks_nxt = tot2;
         endcase
      end
   end

endmodule

// ===== sv/src_rsp_fifo.sv =====
// Response queue: takes up to two beats per cycle, hands out one while pop_ready is high.
// Depends on src_pkg for the depth.
module src_rsp_fifo
   import src_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  logic [WIDTH-1:0] push_data0,
   input  logic [WIDTH-1:0] push_data1,
   output logic             room,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = slot_ff[rd_ptr_ff];
   // room for a full two-beat push regardless of the pop this cycle
   assign room      = (count_ff <= CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_cnt == 2'd2) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= push_data1;
      end
   end

endmodule

// ===== sv/segment_run_coalescer_top.sv =====
// Segment run coalescer top level: input register, run state, response queue.
// Depends on src_pkg, src_step and src_rsp_fifo.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   req      | req_valid/req_ready  | req_seg_addr, req_list_end
//   rsp      | rsp_valid/rsp_ready  | rsp_chunk_addr, rsp_chunk_len,
//            |                      | rsp_chunk_total, rsp_result_last
//   csr      | csr_valid/csr_ready  | csr_seg_shift (always ready)
//
// One segment beat per cycle is taken while the queue has room. A segment
// raises zero, one or two chunk beats; the response port drains one beat per
// cycle while rsp_ready is high. A segment waits in the input register; its
// chunk beats go from there into the queue that feeds rsp. Reset (synchronous)
// empties the input register and queue, closes the run and sets the segment
// shift to 21, or MAX_CHUNK_LOG2 if smaller. A stalled rsp lets the 4-entry
// queue fill until fewer than two entries are free; the input register then
// holds its segment and req_ready drops; nothing is dropped.
module segment_run_coalescer_top
   import src_pkg::*;
#(
   parameter int ADDR_BITS      = ADDR_BITS_DEFAULT,
   parameter int MAX_CHUNK_LOG2 = MAX_CHUNK_LOG2_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_BITS-1:0]  req_seg_addr,
   input  logic                  req_list_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ADDR_BITS-1:0]  rsp_chunk_addr,
   output logic [LEN_BITS-1:0]   rsp_chunk_len,
   output logic [TOTAL_BITS-1:0] rsp_chunk_total,
   output logic                  rsp_result_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SHIFT_BITS-1:0] csr_seg_shift
);

   localparam int RES_W = ADDR_BITS + LEN_BITS + TOTAL_BITS + 1;
   localparam logic [SHIFT_BITS-1:0] MAX_SHIFT = SHIFT_BITS'(MAX_CHUNK_LOG2);
   localparam logic [SHIFT_BITS-1:0] SHIFT_RST =
      (SEG_SHIFT_RESET > MAX_SHIFT) ? MAX_SHIFT : SEG_SHIFT_RESET;

   // ---- segment size register: stored already clamped to the legal range
   logic [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic [LEN_BITS-1:0]   seg_size;
   logic [ADDR_BITS-1:0]  seg_mask;

   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_seg_shift < MIN_SEG_SHIFT) begin
         shift_in = MIN_SEG_SHIFT;
      end else if (csr_seg_shift > MAX_SHIFT) begin
         shift_in = MAX_SHIFT;
      end else begin
         shift_in = csr_seg_shift;
      end
      seg_size = LEN_BITS'(1) << shift_ff;
      seg_mask = ADDR_BITS'(seg_size) - ADDR_BITS'(1);
   end

   // ---- input register; the address is aligned on the way in
   logic                 in_vld_ff, in_vld_in;
   logic [ADDR_BITS-1:0] in_addr_ff;
   logic                 in_last_ff;
   logic                 q_room;
   logic                 advance;
   logic                 req_take;

   assign advance   = in_vld_ff && q_room;
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   // ---- run state
   logic [ADDR_BITS-1:0]  run_start_ff, run_start_in;
   logic [LEN_BITS-1:0]   run_len_ff, run_len_in;
   logic [ADDR_BITS-1:0]  run_end_ff, run_end_in;
   logic                  run_open_ff, run_open_in;
   logic [TOTAL_BITS-1:0] list_chunks_ff, list_chunks_in;
   logic [1:0]            res_cnt;
   logic [RES_W-1:0]      res0_data, res1_data, rsp_data;

   src_step #(
      .ADDR_BITS      (ADDR_BITS),
      .MAX_CHUNK_LOG2 (MAX_CHUNK_LOG2)
   ) u_step (
      .seg_addr        (in_addr_ff),
      .list_end        (in_last_ff),
      .seg_size        (seg_size),
      .run_start       (run_start_ff),
      .run_len         (run_len_ff),
      .run_end         (run_end_ff),
      .run_open        (run_open_ff),
      .list_chunks     (list_chunks_ff),
      .run_start_nxt   (run_start_in),
      .run_len_nxt     (run_len_in),
      .run_end_nxt     (run_end_in),
      .run_open_nxt    (run_open_in),
      .list_chunks_nxt (list_chunks_in),
      .res_cnt         (res_cnt),
      .res0_data       (res0_data),
      .res1_data       (res1_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff       <= SHIFT_RST;
         in_vld_ff      <= 1'b0;
         run_start_ff   <= '0;
         run_len_ff     <= '0;
         run_end_ff     <= '0;
         run_open_ff    <= 1'b0;
         list_chunks_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            shift_ff <= shift_in;
         end
         in_vld_ff <= in_vld_in;
         if (advance) begin
            run_start_ff   <= run_start_in;
            run_len_ff     <= run_len_in;
            run_end_ff     <= run_end_in;
            run_open_ff    <= run_open_in;
            list_chunks_ff <= list_chunks_in;
         end
      end
   end

   // payload of the input register carries no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_addr_ff <= req_seg_addr & ~seg_mask;
         in_last_ff <= req_list_end;
      end
   end

   // ---- response queue
   src_rsp_fifo #(
      .WIDTH (RES_W)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (advance ? res_cnt : 2'd0),
      .push_data0 (res0_data),
      .push_data1 (res1_data),
      .room       (q_room),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

   assign {rsp_chunk_addr, rsp_chunk_len, rsp_chunk_total, rsp_result_last} = rsp_data;

endmodule

// ===== sv/src_checker.sv =====
// Port-level checks on the chunk beats of the segment run coalescer.
// Depends on src_pkg; bound to segment_run_coalescer_top below.
module src_checker
   import src_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ADDR_BITS-1:0]  rsp_chunk_addr,
   input logic [LEN_BITS-1:0]   rsp_chunk_len,
   input logic [TOTAL_BITS-1:0] rsp_chunk_total,
   input logic                  rsp_result_last
);

   localparam logic [LEN_BITS-1:0] MIN_SEG_MASK = (LEN_BITS'(1) << MIN_SEG_SHIFT) - LEN_BITS'(1);

   // a stalled chunk beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_addr)
         && $stable(rsp_chunk_len) && $stable(rsp_chunk_total)
         && $stable(rsp_result_last))
      else $error("rsp beat changed while stalled");

   // chunks are nonempty multiples of the smallest segment
   a_len_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunk_len != '0) && ((rsp_chunk_len & MIN_SEG_MASK) == '0))
      else $error("bad chunk length");

   a_total_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chunk_total != '0)
      else $error("chunk count zero");

   // the second chunk of a segment is queued with the first and counts one up
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_result_last |=> rsp_valid
         && (rsp_chunk_total == TOTAL_BITS'($past(rsp_chunk_total) + TOTAL_BITS'(1))
             || $past(rsp_chunk_total) == TOTAL_MAX))
      else $error("chunk pair out of step");

endmodule

bind segment_run_coalescer_top src_checker #(.ADDR_BITS(ADDR_BITS)) u_src_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_chunk_addr  (rsp_chunk_addr),
   .rsp_chunk_len   (rsp_chunk_len),
   .rsp_chunk_total (rsp_chunk_total),
   .rsp_result_last (rsp_result_last)
);
